[hw/rtl/cpsm_pkg.sv]
// ----------------------------------------------------------------------------
// cpsm_pkg
// Shared types, constants and helpers of the clipped single pixel smoother.
// ----------------------------------------------------------------------------
`default_nettype none
package cpsm_pkg;

  localparam int unsigned BORDER     = 8;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned RING_LINES = 8;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W     = $clog2(RING_LINES);
  localparam int unsigned RAM_DEPTH  = RING_LINES * MAX_WIDTH;
  localparam int unsigned RAM_WIDTH  = 33;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned FW_W       = 12;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PEND_W     = 14;

  localparam logic [41:0] FLAT_LIMIT = 42'd4194304;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CLIP_LEVEL   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CREAD, S_CWAIT, S_CDEC, S_WIN, S_DRAIN1, S_DRAIN2,
    S_CALC1, S_CALC2, S_EMIT
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic       center;
    logic       inner;
    logic [2:0] d;
    logic [2:0] e;
    logic       clr;
    logic       calc1;
    logic       calc2;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic cand;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  function automatic pos_t advance(pos_t p, logic [FW_W-1:0] w, logic [FH_W-1:0] h);
    pos_t              n;
    logic [COL_W:0]    col1;
    logic [ROW_W:0]    row1;
    n    = p;
    col1 = {1'b0, p.col} + 1'b1;
    row1 = {1'b0, p.row};
    if (col1 >= w) begin
      n.col  = '0;
      n.slot = p.slot + 1'b1;
      row1   = {1'b0, p.row} + 1'b1;
    end else begin
      n.col = col1[COL_W-1:0];
    end
    if (row1 >= h) begin
      n.row = '0;
    end else begin
      n.row = row1[ROW_W-1:0];
    end
    return n;
  endfunction

  function automatic logic [21:0] recip_q24(logic [3:0] cnt);
    logic [21:0] r;
    case (cnt)
      4'd5:    r = 22'd3355443;
      4'd6:    r = 22'd2796203;
      4'd7:    r = 22'd2396745;
      4'd8:    r = 22'd2097152;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/clipped_single_pixel_smoother.sv]
// ----------------------------------------------------------------------------
// clipped_single_pixel_smoother
// Repairs isolated clipped pixels of one colour plane from a flat reference.
// ----------------------------------------------------------------------------
// Latency: a pixel leaves 2*W+2 requests after it entered.
// Requests are taken one at a time: one that emits is not through until its result is loaded,
// and a repair candidate first makes 25 window reads through the single line store port.
// Reset clears the counters, the state and the valid flags; the line store and datapath registers hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module clipped_single_pixel_smoother (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // pixel_value, reference_value, is_clipped
  input  wire logic [0:0]  s_axis_tuser,  // is_flush
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // result_value, result_clipped, result_row, result_col
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [cpsm_pkg::FW_W-1:0]  fw_q;
  logic [cpsm_pkg::FH_W-1:0]  fh_q;
  logic [cpsm_pkg::VAL_W-1:0] clip_q;
  logic                       wr;
  cpsm_pkg::cmd_t             cmd;
  cpsm_pkg::status_t          status;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 12'd2048;
      fh_q   <= 13'd4096;
      clip_q <= 16'd16384;
    end else if (wr) begin
      case (paddr[3:2])
        cpsm_pkg::REG_FRAME_WIDTH:  fw_q   <= pwdata[11:0];
        cpsm_pkg::REG_FRAME_HEIGHT: fh_q   <= pwdata[12:0];
        cpsm_pkg::REG_CLIP_LEVEL:   clip_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cpsm_pkg::REG_FRAME_WIDTH:  prdata = {20'b0, fw_q};
      cpsm_pkg::REG_FRAME_HEIGHT: prdata = {19'b0, fh_q};
      cpsm_pkg::REG_CLIP_LEVEL:   prdata = {16'b0, clip_q};
      default:                    prdata = '0;
    endcase
  end

  cpsm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cpsm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .frame_width_i (fw_q),
    .frame_height_i(fh_q),
    .clip_level_i  (clip_q),
    .in_value_i    (s_axis_tdata[15:0]),
    .in_ref_i      (s_axis_tdata[31:16]),
    .in_clip_i     (s_axis_tdata[32]),
    .in_flush_i    (s_axis_tuser[0]),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata)
  );

endmodule
`default_nettype wire

[hw/rtl/cpsm_ram.sv]
// ----------------------------------------------------------------------------
// cpsm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cpsm_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/cpsm_dp.sv]
// ----------------------------------------------------------------------------
// cpsm_dp
// Datapath: line store, position counters, window sums, repair and output.
// ----------------------------------------------------------------------------
`default_nettype none
module cpsm_dp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cpsm_pkg::cmd_t          cmd_i,
  output cpsm_pkg::status_t            status_o,
  input  wire logic [cpsm_pkg::FW_W-1:0]  frame_width_i,
  input  wire logic [cpsm_pkg::FH_W-1:0]  frame_height_i,
  input  wire logic [cpsm_pkg::VAL_W-1:0] clip_level_i,
  input  wire logic [cpsm_pkg::VAL_W-1:0] in_value_i,
  input  wire logic [cpsm_pkg::VAL_W-1:0] in_ref_i,
  input  wire logic                    in_clip_i,
  input  wire logic                    in_flush_i,
  output logic                         m_valid_o,
  input  wire logic                    m_ready_i,
  output logic [39:0]                  m_data_o
);

  localparam int unsigned AW = cpsm_pkg::SLOT_W + cpsm_pkg::COL_W;

  logic [cpsm_pkg::FW_W-1:0] w_eff;
  logic [cpsm_pkg::FH_W-1:0] h_eff;
  cpsm_pkg::pos_t in_pos_q, in_pos_d, out_pos_q, out_pos_d;
  logic [cpsm_pkg::PEND_W-1:0] pend_q, pend_d;

  logic [AW-1:0] waddr, raddr;
  logic [cpsm_pkg::RAM_WIDTH-1:0] rdata;
  logic [cpsm_pkg::SLOT_W-1:0] rd_slot;
  logic [cpsm_pkg::COL_W-1:0]  rd_col;

  logic rv1_q, rc1_q, ri1_q;
  logic v2_q, inner2_q, clip2_q;
  logic [15:0] val2_q, ref2_q;
  logic [31:0] sq_q;
  logic [15:0] c_val_q, c_ref_q;
  logic        c_clip_q;
  logic [20:0] s_q;
  logic [36:0] q_q;
  logic signed [20:0] dsum_q;
  logic [3:0]  cnt_q;
  logic [41:0] q25_q, ss_q, prod_q;
  logic        neg_q;
  logic [19:0] mag;
  logic [41:0] rnd;
  logic [17:0] qv;
  logic signed [19:0] r_s;
  logic [15:0] r_sat, rep_val_q;
  logic        ok_q, flat;
  logic        m_valid_q;
  logic [39:0] m_data_q;
  logic        interior;
  logic [15:0] e_val;
  logic        e_clip;

  always_comb begin
    w_eff = frame_width_i;
    if (frame_width_i < 12'd5) w_eff = 12'd5;
    else if (frame_width_i > 12'(cpsm_pkg::MAX_WIDTH)) w_eff = 12'(cpsm_pkg::MAX_WIDTH);
    h_eff = frame_height_i;
    if (frame_height_i < 13'd5) h_eff = 13'd5;
    else if (frame_height_i > 13'd4096) h_eff = 13'd4096;
  end

  assign waddr   = {in_pos_q.slot, in_pos_q.col};
  assign rd_slot = out_pos_q.slot + cpsm_pkg::SLOT_W'(cmd_i.d) - cpsm_pkg::SLOT_W'(2);
  assign rd_col  = out_pos_q.col + cpsm_pkg::COL_W'(cmd_i.e) - cpsm_pkg::COL_W'(2);
  assign raddr   = {rd_slot, rd_col};

  cpsm_ram #(
    .WIDTH(cpsm_pkg::RAM_WIDTH),
    .DEPTH(cpsm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && !in_flush_i),
    .waddr_i(waddr),
    .wdata_i({in_clip_i, in_ref_i, in_value_i}),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    in_pos_d  = in_pos_q;
    out_pos_d = out_pos_q;
    pend_d    = pend_q;
    if (cmd_i.accept && !in_flush_i) begin
      in_pos_d = cpsm_pkg::advance(in_pos_q, w_eff, h_eff);
      pend_d   = pend_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_pos_d = cpsm_pkg::advance(out_pos_q, w_eff, h_eff);
      pend_d    = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      pend_q    <= '0;
      rv1_q     <= 1'b0;
      rc1_q     <= 1'b0;
      v2_q      <= 1'b0;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      in_pos_q  <= in_pos_d;
      out_pos_q <= out_pos_d;
      pend_q    <= pend_d;
      rv1_q     <= cmd_i.rd;
      rc1_q     <= cmd_i.center;
      v2_q      <= rv1_q && !rc1_q;
      if (cmd_i.clr) ok_q <= 1'b0;
      else if (cmd_i.calc2) ok_q <= flat && cnt_q >= 4'd5 && cnt_q <= 4'd8;
      if (cmd_i.emit) m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  assign mag = (dsum_q < 0) ? 20'(-dsum_q) : 20'(dsum_q);
  assign rnd = prod_q + 42'd8388608;
  assign qv  = rnd[41:24];
  assign flat = (q25_q - ss_q) < cpsm_pkg::FLAT_LIMIT;
  assign r_s = neg_q ? $signed({4'b0, c_ref_q}) - $signed({2'b0, qv})
                     : $signed({4'b0, c_ref_q}) + $signed({2'b0, qv});

  always_comb begin
    if (r_s < 0) r_sat = 16'd0;
    else if (r_s > 20'sd65535) r_sat = 16'hFFFF;
    else r_sat = r_s[15:0];
    if (r_sat < clip_level_i) r_sat = clip_level_i;
  end

  always_ff @(posedge clk_i) begin
    ri1_q <= cmd_i.inner;
    if (rv1_q && rc1_q) begin
      c_val_q  <= rdata[15:0];
      c_ref_q  <= rdata[31:16];
      c_clip_q <= rdata[32];
    end
    val2_q   <= rdata[15:0];
    ref2_q   <= rdata[31:16];
    clip2_q  <= rdata[32];
    inner2_q <= ri1_q;
    sq_q     <= rdata[31:16] * rdata[31:16];
    if (cmd_i.clr) begin
      s_q    <= '0;
      q_q    <= '0;
      dsum_q <= '0;
      cnt_q  <= '0;
    end else if (v2_q) begin
      s_q <= s_q + {5'b0, ref2_q};
      q_q <= q_q + {5'b0, sq_q};
      if (inner2_q && !clip2_q) begin
        cnt_q  <= cnt_q + 1'b1;
        dsum_q <= dsum_q + ($signed({5'b0, val2_q}) - $signed({5'b0, ref2_q}));
      end
    end
    if (cmd_i.calc1) begin
      q25_q  <= {q_q, 4'b0} + {1'b0, q_q, 3'b0} + {4'b0, q_q};
      ss_q   <= s_q * s_q;
      neg_q  <= dsum_q < 0;
      prod_q <= mag * cpsm_pkg::recip_q24(cnt_q);
    end
    if (cmd_i.calc2) begin
      rep_val_q <= r_sat;
    end
    if (cmd_i.emit) begin
      m_data_q <= {out_pos_q.col, out_pos_q.row, e_clip, e_val};
    end
  end

  assign e_val  = ok_q ? rep_val_q : c_val_q;
  assign e_clip = ok_q ? 1'b0 : c_clip_q;

  assign interior = out_pos_q.row >= 12'(cpsm_pkg::BORDER)
                 && ({1'b0, out_pos_q.row} + 13'(cpsm_pkg::BORDER)) < h_eff
                 && out_pos_q.col >= 11'(cpsm_pkg::BORDER)
                 && ({1'b0, out_pos_q.col} + 12'(cpsm_pkg::BORDER)) < w_eff;

  assign status_o.fire = in_flush_i ? (pend_q != '0)
                       : ((pend_q + 1'b1) > ({1'b0, w_eff, 1'b0} + 14'd2));
  assign status_o.cand     = interior && c_clip_q;
  assign status_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("result loaded over a waiting result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 14'd4100)
    else $error("pending count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> m_valid_q)
    else $error("emitted result not presented");

endmodule
`default_nettype wire

[hw/rtl/cpsm_ctrl.sv]
// ----------------------------------------------------------------------------
// cpsm_ctrl
// Sequencer: accept a request; when it fires, read the centre, sweep the 5x5 window for a candidate, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module cpsm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire cpsm_pkg::status_t status_i,
  output cpsm_pkg::cmd_t         cmd_o
);

  cpsm_pkg::state_e state_q, state_d;
  logic [2:0] d_q, d_d, e_q, e_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpsm_pkg::S_IDLE;
      d_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      e_q     <= e_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    e_d       = e_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      cpsm_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.fire) state_d = cpsm_pkg::S_CREAD;
        end
      end
      cpsm_pkg::S_CREAD: begin
        cmd_o.rd     = 1'b1;
        cmd_o.center = 1'b1;
        cmd_o.d      = 3'd2;
        cmd_o.e      = 3'd2;
        state_d      = cpsm_pkg::S_CWAIT;
      end
      cpsm_pkg::S_CWAIT: state_d = cpsm_pkg::S_CDEC;
      cpsm_pkg::S_CDEC: begin
        cmd_o.clr = 1'b1;
        d_d       = '0;
        e_d       = '0;
        state_d   = status_i.cand ? cpsm_pkg::S_WIN : cpsm_pkg::S_EMIT;
      end
      cpsm_pkg::S_WIN: begin
        cmd_o.rd    = 1'b1;
        cmd_o.d     = d_q;
        cmd_o.e     = e_q;
        cmd_o.inner = d_q >= 3'd1 && d_q <= 3'd3 && e_q >= 3'd1 && e_q <= 3'd3;
        if (e_q == 3'd4) begin
          e_d = '0;
          d_d = d_q + 1'b1;
          if (d_q == 3'd4) state_d = cpsm_pkg::S_DRAIN1;
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      cpsm_pkg::S_DRAIN1: state_d = cpsm_pkg::S_DRAIN2;
      cpsm_pkg::S_DRAIN2: state_d = cpsm_pkg::S_CALC1;
      cpsm_pkg::S_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d     = cpsm_pkg::S_CALC2;
      end
      cpsm_pkg::S_CALC2: begin
        cmd_o.calc2 = 1'b1;
        state_d     = cpsm_pkg::S_EMIT;
      end
      cpsm_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = cpsm_pkg::S_IDLE;
        end
      end
      default: state_d = cpsm_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o && status_i.fire) |=> state_q == cpsm_pkg::S_CREAD)
    else $error("firing request did not start a read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpsm_pkg::S_EMIT && status_i.out_free) |=> s_ready_o)
    else $error("no return to idle after emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.accept && cmd_o.rd))
    else $error("write and read requested together");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the clipped single pixel smoother: drives raster
// frames and flush requests with random gaps and back-pressure, predicts each
// emitted pixel from its own copy of the line stores, and checks every field.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [15:0] val;
    logic [15:0] refv;
    logic        clip;
    logic        flush;
  } pixel_t;

  typedef struct {
    logic [15:0] val;
    logic        clip;
    logic [11:0] row;
    logic [10:0] col;
  } pixel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // pixel_value, reference_value, is_clipped
  logic [0:0]  s_axis_tuser = '0;   // is_flush
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // result_value, result_clipped, result_row, result_col
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clipped_single_pixel_smoother i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] val_lines [cpsm_pkg::RING_LINES*cpsm_pkg::MAX_WIDTH];
  logic [15:0] refr_lines [cpsm_pkg::RING_LINES*cpsm_pkg::MAX_WIDTH];
  bit          clip_lines [cpsm_pkg::RING_LINES*cpsm_pkg::MAX_WIDTH];
  bit          wr_lines [cpsm_pkg::RING_LINES*cpsm_pkg::MAX_WIDTH];
  int unsigned cfg_width = 2048, cfg_height = 4096, cfg_clip = 16384;
  int unsigned in_col, in_row, in_slot, out_col, out_row, out_slot, pend;
  pixel_out_t  expected_pixels [$];

  int unsigned errors = 0;
  bit          steady = 1'b0;
  int unsigned hold_left = 0;

  function automatic int unsigned cell_of(int unsigned slot, int unsigned col);
    return (slot % cpsm_pkg::RING_LINES) * cpsm_pkg::MAX_WIDTH + (col % cpsm_pkg::MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_w();
    return cfg_width < 5 ? 5 :
           (cfg_width > cpsm_pkg::MAX_WIDTH ? cpsm_pkg::MAX_WIDTH : cfg_width);
  endfunction

  function automatic int unsigned eff_h();
    return cfg_height < 5 ? 5 : (cfg_height > 4096 ? 4096 : cfg_height);
  endfunction

  function automatic bit is_interior(int unsigned row, int unsigned col);
    return row >= cpsm_pkg::BORDER && row + cpsm_pkg::BORDER < eff_h() &&
           col >= cpsm_pkg::BORDER && col + cpsm_pkg::BORDER < eff_w();
  endfunction

  task automatic step_pos(inout int unsigned col, inout int unsigned row,
                          inout int unsigned slot);
    col++;
    if (col >= eff_w()) begin
      col = 0;
      slot = (slot + 1) % cpsm_pkg::RING_LINES;
      row++;
    end
    if (row >= eff_h()) row = 0;
  endtask

  function automatic bit window_flat(int unsigned slot, int unsigned col);
    longint s, q, v;
    s = 0;
    q = 0;
    for (int d = 0; d < 5; d++)
      for (int e = 0; e < 5; e++) begin
        v = refr_lines[cell_of(slot + cpsm_pkg::RING_LINES + d - 2,
                               col + cpsm_pkg::MAX_WIDTH + e - 2)];
        s += v;
        q += v * v;
      end
    return 25 * q - s * s < 64'd4194304;
  endfunction

  function automatic pixel_out_t smooth_pixel();
    pixel_out_t        o;
    int unsigned       c, n, cnt;
    longint            dsum, r;
    longint unsigned   mag, qt, rcp;
    c = cell_of(out_slot, out_col);
    o.val = val_lines[c];
    o.clip = clip_lines[c];
    o.row = out_row[11:0];
    o.col = out_col[10:0];
    if (is_interior(out_row, out_col) && clip_lines[c]) begin
      cnt = 0;
      dsum = 0;
      for (int d = 0; d < 3; d++)
        for (int e = 0; e < 3; e++) begin
          n = cell_of(out_slot + cpsm_pkg::RING_LINES + d - 1,
                      out_col + cpsm_pkg::MAX_WIDTH + e - 1);
          if (!clip_lines[n]) begin
            cnt++;
            dsum += longint'(val_lines[n]) - longint'(refr_lines[n]);
          end
        end
      if (cnt > 4 && cnt <= 8 && window_flat(out_slot, out_col)) begin
        case (cnt)
          5: rcp = 3355443;
          6: rcp = 2796203;
          7: rcp = 2396745;
          default: rcp = 2097152;
        endcase
        mag = dsum < 0 ? -dsum : dsum;
        qt = (mag * rcp + (64'd1 << 23)) >> 24;
        r = longint'(refr_lines[c]) + (dsum < 0 ? -longint'(qt) : longint'(qt));
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        if (r < cfg_clip) r = cfg_clip;
        o.val = r[15:0];
        o.clip = 1'b0;
      end
    end
    return o;
  endfunction

  task automatic predict_request(pixel_t p);
    int unsigned c;
    bit          fire;
    if (!p.flush) begin
      c = cell_of(in_slot, in_col);
      val_lines[c] = p.val;
      refr_lines[c] = p.refv;
      clip_lines[c] = p.clip;
      wr_lines[c] = 1'b1;
      step_pos(in_col, in_row, in_slot);
      pend++;
      fire = pend > 2 * eff_w() + 2;
    end else begin
      fire = pend > 0;
    end
    if (fire) begin
      expected_pixels.push_back(smooth_pixel());
      step_pos(out_col, out_row, out_slot);
      pend--;
    end
  endtask

  // a flush emits the oldest pixel; skip it when that would read unwritten lines
  function automatic bit flush_safe();
    if (pend == 0 || !is_interior(out_row, out_col)) return 1'b1;
    for (int d = 0; d < 5; d++)
      for (int e = 0; e < 5; e++)
        if (!wr_lines[cell_of(out_slot + cpsm_pkg::RING_LINES + d - 2,
                              out_col + cpsm_pkg::MAX_WIDTH + e - 2)])
          return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_request(pixel_t p);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, p.clip, p.refv, p.val};
    s_axis_tuser <= p.flush;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(p);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [15:0] val, logic [15:0] refv, logic clip);
    pixel_t p;
    p.val = val;
    p.refv = refv;
    p.clip = clip;
    p.flush = 1'b0;
    send_request(p);
  endtask

  task automatic send_flush();
    pixel_t p;
    p.val = 16'($urandom);
    p.refv = 16'($urandom);
    p.clip = 1'($urandom);
    p.flush = 1'b1;
    send_request(p);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cpsm_pkg::REG_FRAME_WIDTH:  cfg_width = data[11:0];
      cpsm_pkg::REG_FRAME_HEIGHT: cfg_height = data[12:0];
      default:                    cfg_clip = data[15:0];
    endcase
  endtask

  // flush out every pending pixel and let the block settle
  task automatic drain();
    while (pend > 0) send_flush();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned cl);
    apb_write(cpsm_pkg::REG_FRAME_WIDTH, w);
    apb_write(cpsm_pkg::REG_FRAME_HEIGHT, h);
    apb_write(cpsm_pkg::REG_CLIP_LEVEL, cl);
  endtask

  // bring the raster position back to the frame origin on a tiny frame
  task automatic realign();
    configure(5, 5, cfg_clip);
    while (in_col != 0 || in_row != 0)
      send_pixel(16'($urandom), 16'($urandom), 1'($urandom));
    drain();
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned cl,
                           bit flat, int unsigned clip_pct);
    int unsigned base;
    logic [15:0] rv, vv;
    configure(w, h, cl);
    base = $urandom_range(0, 65532);
    for (int i = 0; i < int'(eff_w() * eff_h()); i++) begin
      if ($urandom_range(0, 99) < 3 && flush_safe()) send_flush();
      rv = flat ? 16'(base + $urandom_range(0, 3)) : 16'($urandom);
      case ($urandom_range(0, 3))
        0: vv = 16'($urandom);
        1: vv = rv > 16'd2000 ? 16'(rv - $urandom_range(0, 2000)) : rv;
        default: vv = rv < 16'd63000 ? 16'(rv + $urandom_range(0, 2500)) : rv;
      endcase
      send_pixel(vv, rv, $urandom_range(0, 99) < clip_pct);
    end
    drain();
  endtask

  task automatic test_directed();
    configure(2048, 4096, 16384);
    send_flush();
    send_pixel(16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'h5555, 16'hAAAA, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 1'b1);
    drain();
    send_flush();
    drain();
    realign();
  endtask

  task automatic test_repair_frames();
    run_frame($urandom_range(17, 24), $urandom_range(17, 22), 65535, 1'b1, 25);
    run_frame($urandom_range(17, 24), $urandom_range(17, 22), $urandom, 1'b1, 40);
    run_frame($urandom_range(17, 24), $urandom_range(17, 22), 0, 1'b0, 30);
  endtask

  task automatic test_back_pressure();
    steady = 1'b1;
    hold_left = 400;
    run_frame(18, 18, $urandom, 1'b1, 30);
    steady = 1'b0;
  endtask

  task automatic test_clamped_geometry();
    configure(6, 0, 16384);
    repeat (60) send_pixel(16'($urandom), 16'($urandom), 1'($urandom));
    drain();
    realign();
    configure(0, 8191, 16384);
    repeat (60) send_pixel(16'($urandom), 16'($urandom), 1'($urandom));
    drain();
    realign();
  endtask

  always @(negedge clk_i) begin : receiver
    int unsigned wait_left;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      receiver.wait_left = steady ? 0 : $urandom_range(0, 9);
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, m_axis_tdata);
        errors++;
      end else begin
        pixel_out_t e;
        e = expected_pixels.pop_front();
        if (m_axis_tdata[15:0] !== e.val || m_axis_tdata[16] !== e.clip ||
            m_axis_tdata[28:17] !== e.row || m_axis_tdata[39:29] !== e.col) begin
          $display("%0t: expected val %h clip %b row %0d col %0d, got val %h clip %b row %0d col %0d",
                   $time, e.val, e.clip, e.row, e.col, m_axis_tdata[15:0], m_axis_tdata[16],
                   m_axis_tdata[28:17], m_axis_tdata[39:29]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_repair_frames();
    test_back_pressure();
    test_clamped_geometry();
    if (errors == 0 && expected_pixels.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end
endmodule

[clipped_single_pixel_smoother.f]
hw/rtl/cpsm_pkg.sv
hw/rtl/cpsm_ram.sv
hw/rtl/cpsm_dp.sv
hw/rtl/cpsm_ctrl.sv
hw/rtl/clipped_single_pixel_smoother.sv
tb/sv/tb.sv
